### hw/rtl/mss_pkg.sv
// Shared constants, codes and handshake structs for the multipath spray path selector.
package mss_pkg;

  localparam int MaxPaths = 256;
  // 8-bit path fields reach at most 256 paths
  localparam int EffMax   = (MaxPaths < 256) ? MaxPaths : 256;
  localparam int AddrW    = $clog2(MaxPaths);
  localparam int PathW    = 8;
  localparam int CountW   = 9;
  localparam int VisitW   = CountW + 1;
  localparam int OpW      = 3;
  localparam int ModeW    = 2;
  localparam int StW      = 2;
  localparam int CfgIdxW  = 1;

  typedef enum logic [OpW-1:0] {
    OpSelect  = 3'd0,
    OpAck     = 3'd1,
    OpEcn     = 3'd2,
    OpNack    = 3'd3,
    OpTimeout = 3'd4
  } op_e;

  localparam logic [ModeW-1:0] ModeSingle    = 2'd0;
  localparam logic [ModeW-1:0] ModeOblivious = 2'd1;
  localparam logic [ModeW-1:0] ModeAdaptive  = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgSprayMode = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgPathCount = 1'b1;

  localparam logic [StW-1:0] StGood = 2'd0;
  localparam logic [StW-1:0] StBad  = 2'd1;
  localparam logic [StW-1:0] StSkip = 2'd2;

  localparam logic [ModeW-1:0]  SprayModeRst = ModeAdaptive;
  localparam logic [CountW-1:0] PathCountRst = 9'd256;

  typedef enum logic {
    CtrlIdle,
    CtrlEval
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic step;
  } mss_cmd_t;

  typedef struct packed {
    logic last;
  } mss_sts_t;

endpackage

### hw/rtl/mss_status_ram.sv
// Per-path status memory with per-entry valid bits and write-to-read forwarding.
module mss_status_ram (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [mss_pkg::AddrW-1:0] rd_addr_i,
  output logic [mss_pkg::StW-1:0]   rd_data_o,
  input  logic                      wr_en_i,
  input  logic [mss_pkg::AddrW-1:0] wr_addr_i,
  input  logic [mss_pkg::StW-1:0]   wr_data_i
);
  import mss_pkg::*;

  logic [StW-1:0] mem [MaxPaths];
  logic [MaxPaths-1:0] valid_q;
  logic [StW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // entries never written read as good
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else if (valid_q[rd_addr_i]) begin
        rd_data_q <= mem[rd_addr_i];
      end else begin
        rd_data_q <= StGood;
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hw/rtl/mss_datapath.sv
// Datapath: config registers, pointer, totals, path walk and result register.
module mss_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mss_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mss_pkg::CountW-1:0] cfg_data_i,
  input  logic [mss_pkg::OpW-1:0]    operation_i,
  input  logic [mss_pkg::PathW-1:0]  path_index_i,
  input  mss_pkg::mss_cmd_t          cmd_i,
  output mss_pkg::mss_sts_t          sts_o,
  output logic [mss_pkg::PathW-1:0]  chosen_path_o,
  output logic                       path_found_o,
  output logic [mss_pkg::CountW-1:0] bad_count_o,
  output logic [mss_pkg::CountW-1:0] skip_count_o
);
  import mss_pkg::*;

  logic [ModeW-1:0]  mode_q;
  logic [CountW-1:0] count_q;
  logic [PathW-1:0]  ptr_q, ptr_d;
  logic [CountW-1:0] bad_q, bad_d;
  logic [CountW-1:0] skip_q, skip_d;
  op_e               op_q;
  logic [PathW-1:0]  idx_q;
  logic [VisitW-1:0] visits_q, visits_d;

  logic [PathW-1:0]  chosen_q;
  logic              found_q;
  logic [CountW-1:0] bad_out_q, skip_out_q;

  logic [CountW-1:0] n_eff;
  logic [PathW-1:0]  ptr_wrap, ptr_next;
  logic [CountW-1:0] ptr_inc;
  logic              idx_ok;
  logic [VisitW-1:0] visit_inc;
  logic              visit_end;

  logic              last;
  logic [PathW-1:0]  chosen;
  logic              found;
  logic              cont_rd;
  logic              wr_en;
  logic [StW-1:0]    wr_data;
  logic [AddrW-1:0]  wr_addr, rd_addr;
  logic              rd_en;
  logic [StW-1:0]    st;
  logic              load_out;

  mss_status_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (st),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= SprayModeRst;
      count_q <= PathCountRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgSprayMode: mode_q  <= cfg_data_i[ModeW-1:0];
        CfgPathCount: count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    n_eff = count_q;
    if (count_q > CountW'(EffMax)) begin
      n_eff = CountW'(EffMax);
    end
    if (count_q == '0) begin
      n_eff = CountW'(1);
    end
  end

  assign ptr_wrap  = ({1'b0, ptr_q} >= n_eff) ? '0 : ptr_q;
  assign ptr_inc   = {1'b0, ptr_q} + CountW'(1);
  assign ptr_next  = (ptr_inc >= n_eff) ? '0 : ptr_inc[PathW-1:0];
  assign idx_ok    = {1'b0, idx_q} < n_eff;
  assign visit_inc = visits_q + VisitW'(1);
  assign visit_end = visit_inc == {n_eff, 1'b0};

  always_comb begin
    last     = 1'b1;
    chosen   = '0;
    found    = 1'b0;
    bad_d    = bad_q;
    skip_d   = skip_q;
    ptr_d    = ptr_q;
    visits_d = visits_q;
    wr_en    = 1'b0;
    wr_data  = StGood;
    cont_rd  = 1'b0;
    unique case (op_q)
      OpSelect: begin
        unique case (mode_q)
          ModeSingle: begin
            chosen = ptr_q;
            found  = 1'b1;
          end
          ModeOblivious: begin
            chosen = ptr_q;
            found  = 1'b1;
            ptr_d  = ptr_next;
          end
          default: begin
            // adaptive: one path visited per cycle while the controller is not holding for an untaken result
            ptr_d = ptr_next;
            if (st == StGood) begin
              chosen = ptr_q;
              found  = 1'b1;
            end else begin
              if (st == StSkip) begin
                wr_en   = 1'b1;
                wr_data = StGood;
                if (skip_q != '0) skip_d = skip_q - CountW'(1);
              end
              visits_d = visit_inc;
              if (!visit_end) begin
                last    = 1'b0;
                cont_rd = 1'b1;
              end
            end
          end
        endcase
      end
      OpTimeout: begin
        if (idx_ok && (st != StBad)) begin
          if ((st == StSkip) && (skip_q != '0)) skip_d = skip_q - CountW'(1);
          bad_d   = bad_q + CountW'(1);
          wr_en   = 1'b1;
          wr_data = StBad;
        end
      end
      OpEcn, OpNack: begin
        if (idx_ok && (st != StSkip)) begin
          if ((st == StBad) && (bad_q != '0)) bad_d = bad_q - CountW'(1);
          skip_d  = skip_q + CountW'(1);
          wr_en   = 1'b1;
          wr_data = StSkip;
        end
      end
      OpAck: begin
        if (idx_ok) begin
          if ((st == StSkip) && (skip_q != '0)) begin
            skip_d = skip_q - CountW'(1);
          end else if ((st == StBad) && (bad_q != '0)) begin
            bad_d = bad_q - CountW'(1);
          end
          wr_en   = 1'b1;
          wr_data = StGood;
        end
      end
      default: ;
    endcase
    // no status write unless the controller steps this cycle
    wr_en = wr_en && cmd_i.step;
  end

  assign wr_addr = (op_q == OpSelect) ? AddrW'(ptr_q) : AddrW'(idx_q);
  assign rd_en   = cmd_i.accept || (cmd_i.step && cont_rd);
  always_comb begin
    if (cmd_i.accept) begin
      rd_addr = (op_e'(operation_i) == OpSelect) ? AddrW'(ptr_wrap) : AddrW'(path_index_i);
    end else begin
      rd_addr = AddrW'(ptr_next);
    end
  end

  assign load_out = cmd_i.step && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      bad_q  <= '0;
      skip_q <= '0;
    end else if (cmd_i.accept) begin
      if (op_e'(operation_i) == OpSelect) ptr_q <= ptr_wrap;
    end else if (cmd_i.step) begin
      ptr_q  <= ptr_d;
      bad_q  <= bad_d;
      skip_q <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= op_e'(operation_i);
      idx_q    <= path_index_i;
      visits_q <= '0;
    end else if (cmd_i.step) begin
      visits_q <= visits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      chosen_q   <= chosen;
      found_q    <= found;
      bad_out_q  <= bad_d;
      skip_out_q <= skip_d;
    end
  end

  assign sts_o.last    = last;
  assign chosen_path_o = chosen_q;
  assign path_found_o  = found_q;
  assign bad_count_o   = bad_out_q;
  assign skip_count_o  = skip_out_q;

endmodule

### hw/rtl/mss_ctrl.sv
// Controller: request handshake, evaluation sequencing and result valid.
module mss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mss_pkg::mss_cmd_t cmd_o,
  input  mss_pkg::mss_sts_t sts_i
);
  import mss_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CtrlIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      CtrlIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = CtrlEval;
        end
      end
      CtrlEval: begin
        // hold while the previous result has not been taken
        if (out_free) begin
          cmd_o.step = 1'b1;
          if (sts_i.last) begin
            out_valid_d = 1'b1;
            state_d     = CtrlIdle;
          end
        end
      end
      default: state_d = CtrlIdle;
    endcase
  end

  assign in_stall_o  = state_q != CtrlIdle;
  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/multipath_spray_path_selector_top.sv
// Feedback, and a select whose first visited path is good, take a single evaluation step to
// load the registered result; an adaptive select steps past each path that is not good, at
// most 2*n visits in all. New requests stall until the result is loaded; the status memory's
// single read port sets the one-path-per-cycle walk while no result waits. Reset: all paths
// read good via per-entry valid bits (no clearing pass); pointer, totals 0; adaptive, 256 paths.
module multipath_spray_path_selector_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mss_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mss_pkg::CountW-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [mss_pkg::OpW-1:0]     operation_i,
  input  logic [mss_pkg::PathW-1:0]   path_index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mss_pkg::PathW-1:0]   chosen_path_o,
  output logic                        path_found_o,
  output logic [mss_pkg::CountW-1:0]  bad_count_o,
  output logic [mss_pkg::CountW-1:0]  skip_count_o
);
  import mss_pkg::*;

  mss_cmd_t cmd;
  mss_sts_t sts;

  mss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mss_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .operation_i   (operation_i),
    .path_index_i  (path_index_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .chosen_path_o (chosen_path_o),
    .path_found_o  (path_found_o),
    .bad_count_o   (bad_count_o),
    .skip_count_o  (skip_count_o)
  );

endmodule

### tb/sv/multipath_spray_path_selector_top_tb.sv
// Self-checking testbench for the multipath spray path selector top level.
module multipath_spray_path_selector_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mss_pkg::*;

  localparam int unsigned CycleLimit   = 4_000_000;
  localparam int          RandomItems  = 1400;
  localparam int          TailCycles   = 2 * EffMax + 4;
  localparam logic [OpW-1:0]   OpUnusedLo = 3'd5;
  localparam logic [OpW-1:0]   OpUnusedHi = 3'd7;
  localparam logic [ModeW-1:0] ModeSpare  = 2'd3;

  typedef struct packed {
    logic [PathW-1:0]  chosen;
    logic              found;
    logic [CountW-1:0] bad;
    logic [CountW-1:0] skip;
  } path_result_t;

  class spray_scoreboard;
    logic [StW-1:0]    status [EffMax];
    logic [PathW-1:0]  pointer;
    logic [CountW-1:0] bad_total;
    logic [CountW-1:0] skip_total;
    logic [ModeW-1:0]  mode;
    logic [CountW-1:0] count;
    path_result_t      pending_results [$];
    int                errors;
    int                requests;
    int                selects;
    int                misses;

    function new();
      foreach (status[i]) status[i] = StGood;
      pointer    = '0;
      bad_total  = '0;
      skip_total = '0;
      mode       = SprayModeRst;
      count      = PathCountRst;
      errors     = 0;
      requests   = 0;
      selects    = 0;
      misses     = 0;
    endfunction

    function int effective_paths();
      int n;
      n = count;
      if (n > EffMax) n = EffMax;
      if (n == 0) n = 1;
      return n;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CountW-1:0] data);
      if (idx == CfgSprayMode) mode = data[ModeW-1:0];
      else count = data;
    endfunction

    function void mark_path(int p, logic [OpW-1:0] op);
      logic [StW-1:0] old;
      old = status[p];
      if (op == OpTimeout) begin
        if (old != StBad) begin
          if (old == StSkip && skip_total > 0) skip_total--;
          bad_total++;
          status[p] = StBad;
        end
      end else if (op == OpEcn || op == OpNack) begin
        if (old != StSkip) begin
          if (old == StBad && bad_total > 0) bad_total--;
          skip_total++;
          status[p] = StSkip;
        end
      end else begin
        if (old == StSkip && skip_total > 0) skip_total--;
        else if (old == StBad && bad_total > 0) bad_total--;
        status[p] = StGood;
      end
    endfunction

    function void choose_path(output logic [PathW-1:0] chosen, output logic found);
      int n;
      int p;
      n = effective_paths();
      chosen = '0;
      found  = 1'b0;
      if (pointer >= n) pointer = '0;
      if (mode == ModeSingle) begin
        chosen = pointer;
        found  = 1'b1;
        return;
      end
      for (int v = 0; v < 2 * n; v++) begin
        p = pointer;
        pointer = (p + 1 >= n) ? '0 : PathW'(p + 1);
        if (mode == ModeOblivious || status[p] == StGood) begin
          chosen = PathW'(p);
          found  = 1'b1;
          return;
        end
        // skip paths passed over recover
        if (status[p] == StSkip) begin
          status[p] = StGood;
          if (skip_total > 0) skip_total--;
        end
      end
    endfunction

    function void note_request(logic [OpW-1:0] op, logic [PathW-1:0] idx);
      path_result_t r;
      r = '0;
      requests++;
      if (op == OpSelect) begin
        choose_path(r.chosen, r.found);
        selects++;
        if (!r.found) misses++;
      end else if (op <= OpTimeout && idx < effective_paths()) begin
        mark_path(idx, op);
      end
      r.bad  = bad_total;
      r.skip = skip_total;
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [PathW-1:0] chosen, logic found,
                               logic [CountW-1:0] bad, logic [CountW-1:0] skip);
      path_result_t e;
      if (pending_results.size() == 0) begin
        $error("result with no request pending: chosen_path %0d", chosen);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (chosen !== e.chosen) begin
        $error("chosen_path: expected %0d, got %0d", e.chosen, chosen);
        errors++;
      end
      if (found !== e.found) begin
        $error("path_found: expected %0d, got %0d", e.found, found);
        errors++;
      end
      if (bad !== e.bad) begin
        $error("bad_count: expected %0d, got %0d", e.bad, bad);
        errors++;
      end
      if (skip !== e.skip) begin
        $error("skip_count: expected %0d, got %0d", e.skip, skip);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CountW-1:0]   cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [OpW-1:0]      operation_i;
  logic [PathW-1:0]    path_index_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [PathW-1:0]    chosen_path_o;
  logic                path_found_o;
  logic [CountW-1:0]   bad_count_o;
  logic [CountW-1:0]   skip_count_o;

  spray_scoreboard sb;
  int              phase_paths;
  int              random_items;
  int              settings_applied;
  int unsigned     cycle_count;
  bit              no_idle;

  multipath_spray_path_selector_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .path_index_i  (path_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .chosen_path_o (chosen_path_o),
    .path_found_o  (path_found_o),
    .bad_count_o   (bad_count_o),
    .skip_count_o  (skip_count_o)
  );

  always #1 clk_i = ~clk_i;

  // both handshakes sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(operation_i, path_index_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result(chosen_path_o, path_found_o, bad_count_o, skip_count_o);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // result side: random stall ahead of each result
  initial begin : result_sink
    int stall_len;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall_len = no_idle ? 0 : $urandom_range(0, 4);
      if (stall_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send_request(input logic [OpW-1:0] op, input logic [PathW-1:0] idx);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    path_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    random_items++;
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (sb.outstanding() > 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CountW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input logic [CountW-1:0] mode_word,
                               input logic [CountW-1:0] count_word);
    drain_requests();
    repeat (4) @(negedge clk_i);
    write_reg(CfgSprayMode, mode_word);
    write_reg(CfgPathCount, count_word);
    cfg_we_i <= 1'b0;
    phase_paths = sb.effective_paths();
    settings_applied++;
  endtask

  function automatic logic [OpW-1:0] random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return OpSelect;
    if (r < 55) return OpAck;
    if (r < 65) return OpEcn;
    if (r < 73) return OpNack;
    if (r < 90) return OpTimeout;
    return OpW'($urandom_range(OpUnusedLo, OpUnusedHi));
  endfunction

  function automatic logic [PathW-1:0] random_index();
    if ($urandom_range(0, 3) != 0) return PathW'($urandom_range(0, phase_paths - 1));
    return PathW'($urandom_range(0, 255));
  endfunction

  function automatic logic [CountW-1:0] random_count();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 5) return CountW'($urandom_range(1, 8));
    if (r == 6) return CountW'($urandom_range(9, 64));
    if (r == 7) begin
      case ($urandom_range(0, 2))
        0: return '0;
        1: return CountW'(EffMax);
        default: return '1;
      endcase
    end
    if (r == 8) return CountW'($urandom_range(0, 511));
    return CountW'(1);
  endfunction

  initial begin : stimulus
    logic [ModeW-1:0]  mode;
    logic [CountW-1:0] mode_word;
    int                phase_len;
    logic [OpW-1:0]    op;

    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CfgSprayMode;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    operation_i  = OpSelect;
    path_index_i = '0;
    out_stall_i  = 1'b0;
    no_idle      = 1'b0;
    random_items = 0;
    settings_applied = 0;
    sb = new();
    phase_paths = sb.effective_paths();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset defaults, every operation, extreme indexes
    send_request(OpSelect, 8'd0);
    send_request(OpAck, 8'd255);
    send_request(OpTimeout, 8'd0);
    send_request(OpEcn, 8'd1);
    send_request(OpNack, 8'd2);
    send_request(OpAck, 8'd1);
    send_request(OpUnusedLo, 8'd3);
    send_request(OpUnusedHi, 8'd255);
    send_request(OpSelect, 8'hFF);
    send_request(OpSelect, 8'd0);
    // shrink to 4 paths: pointer wraps, all bad, no path found
    apply_setting(CountW'(ModeAdaptive), CountW'(4));
    send_request(OpTimeout, 8'd200);
    send_request(OpTimeout, 8'd1);
    send_request(OpTimeout, 8'd2);
    send_request(OpTimeout, 8'd3);
    send_request(OpSelect, 8'd0);
    send_request(OpAck, 8'd2);
    send_request(OpSelect, 8'd0);
    // zero path count acts as one path; single mode ignores status
    apply_setting(CountW'(ModeSingle), '0);
    send_request(OpSelect, 8'd0);
    send_request(OpTimeout, 8'd0);
    send_request(OpSelect, 8'd0);
    apply_setting(CountW'(ModeOblivious), '1);
    send_request(OpSelect, 8'd0);
    send_request(OpSelect, 8'd0);
    // spare mode code with high data bits set behaves adaptive
    apply_setting({7'h7F, ModeSpare}, CountW'(1));
    send_request(OpSelect, 8'd0);

    // full width: every path bad, then a select walks two full turns
    apply_setting(CountW'(ModeAdaptive), CountW'(EffMax));
    random_items = 0;
    for (int p = 0; p < EffMax; p++) send_request(OpTimeout, PathW'(p));
    send_request(OpSelect, 8'd0);
    for (int p = 0; p < EffMax; p += 2) send_request(OpNack, PathW'(p));
    send_request(OpSelect, 8'd0);
    send_request(OpSelect, 8'd0);

    while (random_items < RandomItems) begin
      mode = ModeW'($urandom_range(0, 3));
      mode_word = {7'($urandom_range(0, 127)), mode};
      apply_setting(mode_word, random_count());
      no_idle = ($urandom_range(0, 3) == 0);
      // small sets: mark every path first so the adaptive walk gets long
      if (phase_paths <= 32 && $urandom_range(0, 2) == 0) begin
        for (int p = 0; p < phase_paths; p++) begin
          case ($urandom_range(0, 5))
            0: op = OpAck;
            1: op = OpEcn;
            2: op = OpNack;
            default: op = OpTimeout;
          endcase
          send_request(op, PathW'(p));
        end
      end
      phase_len = $urandom_range(30, 90);
      for (int i = 0; i < phase_len; i++) begin
        send_request(random_op(), random_index());
        if ($urandom_range(0, 63) == 0) drain_requests();
      end
    end

    drain_requests();
    repeat (TailCycles) @(posedge clk_i);
    $display("Covered %0d requests (%0d selects, %0d without a usable path) over %0d settings",
             sb.requests, sb.selects, sb.misses, settings_applied);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/mss_pkg.sv
hw/rtl/mss_status_ram.sv
hw/rtl/mss_datapath.sv
hw/rtl/mss_ctrl.sv
hw/rtl/multipath_spray_path_selector_top.sv
tb/sv/multipath_spray_path_selector_top_tb.sv
